// File: src/complex_one_pole_lowpass_rgba_unit_assert.svh
// Assertion macros for the complex one-pole low-pass RGBA unit.
// Used by the top level; expects a clock named clk and reset named rst.
`ifndef COMPLEX_ONE_POLE_LOWPASS_RGBA_UNIT_ASSERT_SVH
`define COMPLEX_ONE_POLE_LOWPASS_RGBA_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define CPLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define CPLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cplp_pkg.sv
// Shared types and constants for the complex one-pole low-pass RGBA unit.
// No dependencies; imported by every module of the block.
package cplp_pkg;

  // Field and state widths
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int BIAS_W     = 19;
  localparam int SEL_W      = 3;
  localparam int STATE_W    = 48;
  localparam int NUM_SLOTS  = 4;
  localparam int COEF_FRAC  = 16;
  localparam int MUL_SPLIT  = 24;

  // Parameter defaults
  localparam int CHANNELS_DEF  = 4;
  localparam int FRAC_BITS_DEF = 16;

  // Configuration port
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 2;
  localparam int ADDR_W    = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_COEF_REAL    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_IMAG    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BIAS         = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA_SELECT = 2'd3;

  // Register reset values
  localparam logic signed [COEF_W-1:0] COEF_REAL_RST = 18'sd32768;
  localparam logic signed [COEF_W-1:0] COEF_IMAG_RST = 18'sd0;
  localparam logic signed [BIAS_W-1:0] BIAS_RST      = 19'sd2;
  localparam logic [SEL_W-1:0]         SEL_RST       = 3'd0;

  // alpha_select bits
  localparam int SEL_REAL = 0;
  localparam int SEL_IMAG = 1;
  localparam int SEL_BIAS = 2;

  // Alpha as bias: 4*alpha - ALPHA_BIAS_OFS quarter units (alpha - 32767.25)
  localparam logic [BIAS_W:0] ALPHA_BIAS_OFS = 20'd131069;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic [SAMPLE_W-1:0] alpha;
    logic                line_start;
  } pix_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] out_red;
    logic [SAMPLE_W-1:0] out_green;
    logic [SAMPLE_W-1:0] out_blue;
    logic [SAMPLE_W-1:0] out_alpha;
  } pix_out_t;

  // Per-lane control from the top level
  typedef struct packed {
    logic load;
    logic first;
  } lane_ctl_t;

endpackage

// File: src/cplp_lane.sv
// One filter lane: complex state of one channel and its update.
// Depends on cplp_pkg.
module cplp_lane import cplp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lane_ctl_t                 ctl,
  input  logic [SAMPLE_W-1:0]       sample,
  input  logic signed [COEF_W-1:0]  cr,
  input  logic signed [COEF_W-1:0]  ci,
  output logic signed [STATE_W-1:0] real_q
);

  localparam int DW  = STATE_W + 1;                 // difference / operand width
  localparam int HW  = DW - MUL_SPLIT;              // high part of an operand
  localparam int LW  = MUL_SPLIT + 1;               // low part, zero-extended
  localparam int OPW = COEF_W + 1;                  // coefficient, room for negation
  localparam int PHW = OPW + HW;
  localparam int PLW = OPW + LW;
  localparam int SW  = ((PHW > PLW) ? PHW : PLW) + 1;
  localparam int MW  = SW + MUL_SPLIT - COEF_FRAC + 1;
  localparam int RW  = MW + 1;

  logic signed [STATE_W-1:0] line_real, line_imag;
  logic signed [STATE_W-1:0] real_next, imag_next;
  logic signed [DW-1:0]      v, d, im_ext;
  logic signed [OPW-1:0]     cr_x, ci_x, nci;
  logic signed [MW-1:0]      mac_i, mac_r;
  logic signed [RW-1:0]      sum_r;

  // floor((a*d + b*e) / 2^COEF_FRAC), operands split into high and low parts
  function automatic logic signed [MW-1:0] mac2(
    input logic signed [OPW-1:0] a,
    input logic signed [DW-1:0]  dv,
    input logic signed [OPW-1:0] b,
    input logic signed [DW-1:0]  ev
  );
    logic signed [HW-1:0]  dh, eh;
    logic signed [LW-1:0]  dl, el;
    logic signed [PHW-1:0] p_dh, p_eh;
    logic signed [PLW-1:0] p_dl, p_el;
    logic signed [SW-1:0]  hi, lo;
    logic signed [MW-1:0]  hi_sc, lo_sc;
    dh    = dv[DW-1:MUL_SPLIT];
    eh    = ev[DW-1:MUL_SPLIT];
    dl    = $signed({1'b0, dv[MUL_SPLIT-1:0]});
    el    = $signed({1'b0, ev[MUL_SPLIT-1:0]});
    p_dh  = a * dh;
    p_eh  = b * eh;
    p_dl  = a * dl;
    p_el  = b * el;
    hi    = SW'(p_dh) + SW'(p_eh);
    lo    = SW'(p_dl) + SW'(p_el);
    hi_sc = MW'(hi) <<< (MUL_SPLIT - COEF_FRAC);
    lo_sc = MW'(lo >>> COEF_FRAC);
    return hi_sc + lo_sc;
  endfunction

  // Saturate to the signed state range
  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [RW-1:0] x);
    logic [RW-STATE_W:0] top;
    top = x[RW-1:STATE_W-1];
    if ((&top) || !(|top)) begin
      return x[STATE_W-1:0];
    end else if (x[RW-1]) begin
      return {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_W-1){1'b1}}};
    end
  endfunction

  // Operands: sample in state format, difference to the old real part
  always_comb begin
    v      = $signed(DW'(sample) << FRAC_BITS);
    d      = DW'(line_real) - v;
    im_ext = DW'(line_imag);
    cr_x   = OPW'(cr);
    ci_x   = OPW'(ci);
    nci    = -ci_x;
  end

  // Complex pole update, or restart at the line start
  always_comb begin
    mac_i = mac2(cr_x, im_ext, ci_x, d);
    mac_r = mac2(cr_x, d, nci, im_ext);
    sum_r = RW'(v) + RW'(mac_r);
    if (ctl.first) begin
      real_next = v[STATE_W-1:0];
      imag_next = '0;
    end else begin
      real_next = sat_state(sum_r);
      imag_next = sat_state(RW'(mac_i));
    end
  end

  // Advance the state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      line_real <= '0;
      line_imag <= '0;
    end else if (ctl.load) begin
      line_real <= real_next;
      line_imag <= imag_next;
    end
  end

  assign real_q = line_real;

endmodule

// File: src/cplp_merge.sv
// Merge stage: adds bias to each lane's real part, clamps, and holds the result.
// Depends on cplp_pkg.
module cplp_merge import cplp_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic signed [BIAS_W+FRAC_BITS-3:0]   bs,
  input  logic [CHANNELS-1:0][STATE_W-1:0]     real_in,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output pix_out_t                             out_data
);

  localparam int YW = STATE_W + 1;

  logic [NUM_SLOTS-1:0][SAMPLE_W-1:0] res;
  pix_out_t                           res_pix;

  // Clamp each used channel; unused slots read zero
  for (genvar c = 0; c < NUM_SLOTS; c++) begin : g_slot
    if (c < CHANNELS) begin : g_used
      logic signed [YW-1:0] y;
      always_comb begin
        y = YW'($signed(real_in[c])) + YW'(bs);
        if (y[YW-1]) begin
          res[c] = '0;
        end else if (|y[YW-2:FRAC_BITS+SAMPLE_W]) begin
          res[c] = '1;
        end else begin
          res[c] = y[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
        end
      end
    end else begin : g_unused
      assign res[c] = '0;
    end
  end

  assign res_pix = '{out_red: res[0], out_green: res[1], out_blue: res[2],
                     out_alpha: res[3]};

  // Output register: fill on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res_pix;
    end
  end

endmodule

// File: src/complex_one_pole_lowpass_rgba_unit.sv
// Complex one-pole IIR low-pass filter over an RGBA pixel stream.
// Depends on cplp_pkg, cplp_lane, cplp_merge and the assertion macro header.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one RGBA pixel with
//   16-bit channels and a line_start flag; output channel (out_valid /
//   out_stall / out_data) carries the four filtered, clamped channels.
//   A request is taken at a clock edge with valid high and stall low.
//   Configuration (APB-style port, registers at 0, 4, 8, 12; pready always high)
//   is written by the user only while no request is in flight; not enforced.
// Timing:
//   One pixel per clock sustained while out_stall is low. A result passes the
//   lane state, written at the accepting edge with its complex state loop
//   closing through the lane multipliers, and then the output register, which
//   is loaded with the biased, clamped result when the lane stage moves on.
// Reset (rst, synchronous): clears the filter state and in-flight results
//   and loads the register defaults.
// Stall: the output register holds its result; the next pixel is still taken
//   while the lane stage is free, after which in_stall rises until it drains.
module complex_one_pole_lowpass_rgba_unit import cplp_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  pix_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pix_out_t          out_data
);

`include "complex_one_pole_lowpass_rgba_unit_assert.svh"

  localparam int BSW = BIAS_W + FRAC_BITS - 2;

  logic signed [COEF_W-1:0]          coef_real, coef_imag;
  logic signed [BIAS_W-1:0]          bias;
  logic [SEL_W-1:0]                  alpha_select;
  logic [REG_IDX_W-1:0]              reg_idx;
  logic                              cfg_wr;

  logic                              in_acc, s1_valid, s1_take, out_free;
  logic signed [BSW-1:0]             bs_q, bs_next;
  logic signed [COEF_W-1:0]          cr_sel, ci_sel;
  logic signed [BIAS_W-1:0]          bq_sel;
  logic [COEF_W-2:0]                 alpha_coef;
  logic [BIAS_W:0]                   alpha_bias;
  logic [NUM_SLOTS-1:0][SAMPLE_W-1:0] samples;
  logic [CHANNELS-1:0][STATE_W-1:0]  lane_real;
  lane_ctl_t                         lane_ctl;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_real    <= COEF_REAL_RST;
      coef_imag    <= COEF_IMAG_RST;
      bias         <= BIAS_RST;
      alpha_select <= SEL_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_COEF_REAL:    coef_real    <= pwdata[COEF_W-1:0];
        REG_COEF_IMAG:    coef_imag    <= pwdata[COEF_W-1:0];
        REG_BIAS:         bias         <= pwdata[BIAS_W-1:0];
        REG_ALPHA_SELECT: alpha_select <= pwdata[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COEF_REAL:    prdata = APB_DW'(coef_real);
      REG_COEF_IMAG:    prdata = APB_DW'(coef_imag);
      REG_BIAS:         prdata = APB_DW'(bias);
      REG_ALPHA_SELECT: prdata = APB_DW'(alpha_select);
      default:          prdata = '0;
    endcase
  end

  // Pick each setting from its register or from the pixel alpha
  always_comb begin
    alpha_coef = (COEF_W-1)'(in_data.alpha) + (COEF_W-1)'(in_data.alpha[SAMPLE_W-1]);
    alpha_bias = {2'b00, in_data.alpha, 2'b00} - ALPHA_BIAS_OFS;
    cr_sel     = alpha_select[SEL_REAL] ? $signed({1'b0, alpha_coef}) : coef_real;
    ci_sel     = alpha_select[SEL_IMAG] ? $signed({1'b0, alpha_coef}) : coef_imag;
    bq_sel     = alpha_select[SEL_BIAS] ? $signed(alpha_bias[BIAS_W-1:0]) : bias;
    bs_next    = BSW'(bq_sel) <<< (FRAC_BITS - 2);
  end

  // Handshake: lane stage moves on when the output register is free
  assign out_free = !out_valid || !out_stall;
  assign s1_take  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      bs_q <= bs_next;
    end
  end

  // Lanes, one per filtered channel
  assign samples  = {in_data.alpha, in_data.blue, in_data.green, in_data.red};
  assign lane_ctl = '{load: in_acc, first: in_data.line_start};

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    cplp_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (lane_ctl),
      .sample (samples[c]),
      .cr     (cr_sel),
      .ci     (ci_sel),
      .real_q (lane_real[c])
    );
  end

  cplp_merge #(
    .CHANNELS  (CHANNELS),
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_take),
    .bs        (bs_q),
    .real_in   (lane_real),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A request is taken only when the lane stage is empty or draining
  `CPLP_ASSERT_NOW(a_acc_room, in_acc, (!s1_valid || s1_take), "request taken into full stage")
  // Every taken request occupies the lane stage next cycle
  `CPLP_ASSERT_NEXT(a_acc_fill, in_acc, s1_valid, "accepted request lost")
  // A blocked lane stage keeps its request and bias
  `CPLP_ASSERT_NEXT(a_s1_hold, (s1_valid && !s1_take), (s1_valid && $stable(bs_q)), "lane stage dropped")
  // A lane-stage move always lands in the output register
  `CPLP_ASSERT_NEXT(a_out_fill, s1_take, out_valid, "result not registered")

endmodule
